>>> rtl/i2a_pkg.sv
// Shared types, constants and the digit glyph function for the integer to ASCII converter.
// No dependencies.
package i2a_pkg;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [4:0] RADIX_MIN  = 5'd2;
   localparam logic [4:0] RADIX_MAX  = 5'd16;
   localparam logic [4:0] RADIX_DEC  = 5'd10;
   localparam int unsigned CHUNK_BITS = 8;

   typedef struct packed {
      logic [31:0] value;
      logic [4:0]  radix;
      logic        signed_mode;
   } i2a_req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } i2a_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIVIDE,
      ST_PUSH,
      ST_READ,
      ST_EMIT
   } i2a_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic pop;
      logic sign_sel;
   } i2a_cmd_type;

   typedef struct packed {
      logic negative;
      logic pass_last;
      logic quot_zero;
      logic stack_empty;
   } i2a_status_type;

   function automatic logic [7:0] digit_glyph(input logic [3:0] d);
      logic [7:0] g;
      if (d < 4'd10) begin
         g = 8'h30 + {4'd0, d};
      end else begin
         g = 8'h37 + {4'd0, d};
      end
      return g;
   endfunction

endpackage

>>> rtl/i2a_ctrl.sv
// Controller state machine for the integer to ASCII converter.
// Depends on i2a_pkg.
module i2a_ctrl import i2a_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  i2a_status_type status,
   output i2a_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   i2a_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.negative ? ST_SIGN : ST_DIVIDE;
            end
         end
         ST_SIGN:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.pass_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH:   state_in = status.quot_zero ? ST_READ : ST_DIVIDE;
         ST_READ:   state_in = ST_EMIT;
         ST_EMIT:   state_in = status.stack_empty ? ST_IDLE : ST_READ;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SIGN: begin
            cmd.sign_sel = 1'b1;
            rsp_valid    = 1'b1;
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_PUSH:   cmd.push     = 1'b1;
         ST_READ:   cmd.pop      = 1'b1;
         ST_EMIT:   rsp_valid    = 1'b1;
         default:   busy         = 1'b0;
      endcase
   end

endmodule

>>> rtl/i2a_datapath.sv
// Datapath: operand load and sign handling, chunked long division by the radix,
// digit stack memory and result character selection. Depends on i2a_pkg.
module i2a_datapath import i2a_pkg::*; #(
   parameter int unsigned WIDTH = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  i2a_req_type    req_data,
   input  i2a_cmd_type    cmd,
   output i2a_status_type status,
   output i2a_rsp_type    rsp_data
);

   localparam int unsigned PASSES = (WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int unsigned PADW   = PASSES * CHUNK_BITS;
   localparam int unsigned AW     = $clog2(WIDTH);
   localparam int unsigned CW     = $clog2(WIDTH + 1);
   localparam int unsigned PCW    = (PASSES > 1) ? $clog2(PASSES) : 1;

   logic [PADW-1:0]  quot_ff, quot_in;
   logic [3:0]       rem_ff, rem_in;
   logic [4:0]       base_ff, base_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [PCW-1:0]   pass_ff, pass_in;
   logic [7:0]       rd_ff;
   logic [7:0]       digit_mem [WIDTH];

   logic [4:0]       base_clamp;
   logic [WIDTH-1:0] operand;
   logic [WIDTH-1:0] magnitude;
   logic             negative;
   logic [CW-1:0]    cnt_dec;
   logic [3:0]       step_rem;
   logic [7:0]       step_bits;

   always_comb begin
      if (req_data.radix > RADIX_MAX) begin
         base_clamp = RADIX_MAX;
      end else if (req_data.radix < RADIX_MIN) begin
         base_clamp = RADIX_MIN;
      end else begin
         base_clamp = req_data.radix;
      end
   end

   assign operand   = WIDTH'(req_data.value);
   assign negative  = req_data.signed_mode && (base_clamp == RADIX_DEC) && operand[WIDTH-1];
   assign magnitude = negative ? (~operand + WIDTH'(1)) : operand;
   assign cnt_dec   = cnt_ff - CW'(1);

   // restoring division of one 8-bit chunk, one quotient bit per step
   always_comb begin
      logic [4:0] r;
      logic [7:0] chunk;
      chunk = quot_ff[PADW-1 -: CHUNK_BITS];
      r     = {1'b0, rem_ff};
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         r = {r[3:0], chunk[i]};
         if (r >= base_ff) begin
            r            = r - base_ff;
            step_bits[i] = 1'b1;
         end else begin
            step_bits[i] = 1'b0;
         end
      end
      step_rem = r[3:0];
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      base_in = base_ff;
      pass_in = pass_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         quot_in = PADW'(magnitude);
         rem_in  = '0;
         base_in = base_clamp;
         pass_in = '0;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         quot_in = (quot_ff << CHUNK_BITS) | PADW'(step_bits);
         rem_in  = step_rem;
         pass_in = pass_ff + PCW'(1);
      end else if (cmd.push) begin
         rem_in  = '0;
         pass_in = '0;
         cnt_in  = cnt_ff + CW'(1);
      end else if (cmd.pop) begin
         cnt_in  = cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pass_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         digit_mem[cnt_ff[AW-1:0]] <= digit_glyph(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_ff <= digit_mem[cnt_dec[AW-1:0]];
      end
   end

   assign status.negative    = negative;
   assign status.pass_last   = (pass_ff == PCW'(PASSES - 1));
   assign status.quot_zero   = (quot_ff == '0);
   assign status.stack_empty = (cnt_ff == '0);

   assign rsp_data.character = cmd.sign_sel ? CHAR_MINUS : rd_ff;
   assign rsp_data.last      = !cmd.sign_sel && (cnt_ff == '0);

endmodule

>>> rtl/integer_to_ascii_digits_core.sv
// Integer to ASCII digits, radix 2..16, MS digit first. P = ceil(WIDTH/8) division passes.
// Each digit takes P passes in the chunked divider (8 quotient bits per cycle) and a push onto
// the digit stack memory; each character is then popped in a read and an emit state. Busy stays
// high from the accepting edge to the last character, a leading minus sign, if any, coming first;
// one item at a time, the next transfer is taken as soon as busy is low.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-high reset returns the controller to idle; no clearing pass.
module integer_to_ascii_digits_core import i2a_pkg::*; #(
   parameter int unsigned WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  i2a_req_type req_data,
   output logic        rsp_valid,
   output i2a_rsp_type rsp_data
);

   i2a_cmd_type    cmd;
   i2a_status_type status;

   i2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   i2a_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   a_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after transfer in");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !busy)
      else $error("still busy after last transfer");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.character == CHAR_MINUS) |-> !rsp_data.last)
      else $error("minus sign flagged last");

endmodule
